FILE: rtl/core/ffc_pkg.sv
// Shared types and constants for the flat-field correction block.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps

package ffc_pkg;

  localparam int unsigned MaxPixels = 16777216;
  localparam logic [24:0] MaxValid = 25'(MaxPixels);
  localparam logic [25:0] MaxClamped = 26'(3 * MaxPixels);

  localparam int unsigned DivW = 48;
  localparam int unsigned DvsW = 25;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeFlat = 2'd1;
  localparam logic [1:0] ModeCorrect = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatNoValid = 2'd1;
  localparam logic [1:0] StatSat = 2'd2;

  localparam logic [2:0] RegFloorAddr = 3'd0;

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic       div_sel;   // 0: normaliser, 1: corrected sample
    logic       cap_norm;
    logic       cap_prod;
    logic       cap_res;
    logic       commit;
    logic [1:0] chan;
  } ffc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } ffc_sts_t;

endpackage

FILE: rtl/core/flat_field_correction.sv
// Top level of the flat-field correction block: stream ports and register port.
// Depends on ffc_pkg, ffc_ctrl and ffc_datapath.
//
// Port group   Dir  Contents
// s_axis_*     in   mode and image/flat pixel, one word per pixel
// m_axis_*     out  corrected pixel, status and statistics totals
// APB          in   floor_level register at byte address 0
//
// Clear and flat words go from the load through the check state straight to the commit.
// A correct word runs two divisions per channel on the one serial divider.
// Input is taken only between words; a waiting result stalls the next one in its
// last step. Reset clears all statistics and sets the floor to 1.
`timescale 1ns / 1ps

module flat_field_correction (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode, image_red, image_green, image_blue, flat_red, flat_green, flat_blue, zeros
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red, out_green, out_blue, status, valid_total, clamped_total, zeros
  output logic [103:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ffc_pkg::*;

  ffc_cmd_t    cmd;
  ffc_sts_t    sts;
  logic [15:0] image [3];
  logic [15:0] flat [3];
  logic [15:0] osmp [3];
  logic [1:0]  ostat;
  logic [25:0] ovt, oct;
  logic [15:0] floor_val;
  logic        cfg_we;

  assign image[0] = s_axis_tdata[17:2];
  assign image[1] = s_axis_tdata[33:18];
  assign image[2] = s_axis_tdata[49:34];
  assign flat[0]  = s_axis_tdata[65:50];
  assign flat[1]  = s_axis_tdata[81:66];
  assign flat[2]  = s_axis_tdata[97:82];

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == RegFloorAddr);
  assign prdata = (paddr == RegFloorAddr) ? {16'd0, floor_val} : 32'd0;

  ffc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (s_axis_tdata[1:0]),
    .image_i         (image),
    .flat_i          (flat),
    .cfg_we_i        (cfg_we),
    .cfg_floor_i     (pwdata[15:0]),
    .floor_o         (floor_val),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_sample_o    (osmp),
    .status_o        (ostat),
    .valid_total_o   (ovt),
    .clamped_total_o (oct)
  );

  assign m_axis_tdata = {2'b00, oct, ovt, ostat, osmp[2], osmp[1], osmp[0]};

endmodule

FILE: rtl/core/ffc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all channels.
// Depends on ffc_pkg for the operand widths.
`timescale 1ns / 1ps

module ffc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ffc_pkg::DivW-1:0] dividend_i,
  input  logic [ffc_pkg::DvsW-1:0] divisor_i,
  output logic                     done_o,
  output logic [ffc_pkg::DivW-1:0] quotient_o
);
  import ffc_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] dvd_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DvsW:0]   trial;
  logic            fits;

  assign trial = {rem_q[DvsW-1:0], dvd_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts out at the top and collects quotient bits at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
      dvd_q <= {dvd_q[DivW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

FILE: rtl/core/ffc_ctrl.sv
// Sequencer for the flat-field correction block: handshake and division steps.
// Depends on ffc_pkg for the command and status structs.
`timescale 1ns / 1ps

module ffc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ffc_pkg::ffc_sts_t sts_i,
  output ffc_pkg::ffc_cmd_t cmd_o
);
  import ffc_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SNGo   = 3'd2;
  localparam logic [2:0] SNWait = 3'd3;
  localparam logic [2:0] SMul   = 3'd4;
  localparam logic [2:0] SQGo   = 3'd5;
  localparam logic [2:0] SQWait = 3'd6;
  localparam logic [2:0] SDone  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] chan_q, chan_d;

  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = SCheck;
        end
      end
      SCheck: begin
        chan_d  = '0;
        state_d = sts_i.need_div ? SNGo : SDone;
      end
      SNGo: begin
        cmd_o.div_start = 1'b1;
        state_d = SNWait;
      end
      SNWait: begin
        if (sts_i.div_done) begin
          cmd_o.cap_norm = 1'b1;
          state_d = SMul;
        end
      end
      SMul: begin
        cmd_o.cap_prod = 1'b1;
        state_d = SQGo;
      end
      SQGo: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d = SQWait;
      end
      SQWait: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.cap_res = 1'b1;
          if (chan_q == 2'd2) begin
            state_d = SDone;
          end else begin
            chan_d  = chan_q + 1'b1;
            state_d = SNGo;
          end
        end
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    cmd_o.chan = chan_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      chan_q  <= '0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);

  a_start_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !sts_i.div_done)
    else $error("divider finished one cycle after start");
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q != 2'd3)
    else $error("channel counter out of range");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free && state_q == SDone)
    else $error("result committed while output register busy");

endmodule

FILE: rtl/core/ffc_datapath.sv
// Datapath: flat statistics, normaliser and product registers, output word register.
// Depends on ffc_pkg and instantiates the shared divider ffc_div.
`timescale 1ns / 1ps

module ffc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffc_pkg::ffc_cmd_t cmd_i,
  output ffc_pkg::ffc_sts_t sts_o,
  input  logic [1:0]        mode_i,
  input  logic [15:0]       image_i [3],
  input  logic [15:0]       flat_i [3],
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_floor_i,
  output logic [15:0]       floor_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       out_sample_o [3],
  output logic [1:0]        status_o,
  output logic [25:0]       valid_total_o,
  output logic [25:0]       clamped_total_o
);
  import ffc_pkg::*;

  logic [15:0] floor_q;
  logic [1:0]  mode_q;
  logic [15:0] img_q [3];
  logic [15:0] flat_q [3];
  logic [39:0] sum_q [3];
  logic [24:0] valid_q [3];
  logic [25:0] clamped_q;
  logic [23:0] norm_q;
  logic [39:0] prod_q;
  logic [15:0] res_q [3];
  logic        sat_q;
  logic        ovalid_q;
  logic [15:0] osmp_q [3];
  logic [1:0]  ostat_q;
  logic [25:0] ovt_q, oct_q;

  logic [15:0] fl;
  logic [39:0] sum_d [3];
  logic [24:0] valid_d [3];
  logic [25:0] clamped_d;
  logic [25:0] cl_step [4];
  logic [15:0] den;
  logic [DivW-1:0] dividend, quotient;
  logic [DvsW-1:0] divisor;
  logic        div_done;
  logic        all_valid;

  assign fl = (floor_q == 16'd0) ? 16'd1 : floor_q;
  assign all_valid = (valid_q[0] != '0) && (valid_q[1] != '0) && (valid_q[2] != '0);

  // Statistics after the current word; the clamped count saturates channel by channel.
  always_comb begin
    cl_step[0] = clamped_q;
    for (int c = 0; c < 3; c++) begin
      sum_d[c]   = sum_q[c];
      valid_d[c] = valid_q[c];
      cl_step[c+1] = cl_step[c];
      if (mode_q == ModeClear) begin
        sum_d[c]   = '0;
        valid_d[c] = '0;
      end else if (mode_q == ModeFlat) begin
        if (flat_q[c] > fl) begin
          if (valid_q[c] < MaxValid) begin
            sum_d[c]   = sum_q[c] + 40'(flat_q[c]);
            valid_d[c] = valid_q[c] + 1'b1;
          end
        end else if (cl_step[c] < MaxClamped) begin
          cl_step[c+1] = cl_step[c] + 1'b1;
        end
      end
    end
    clamped_d = (mode_q == ModeClear) ? '0 : cl_step[3];
  end

  assign den = (flat_q[cmd_i.chan] > fl) ? flat_q[cmd_i.chan] : fl;

  always_comb begin
    if (cmd_i.div_sel) begin
      dividend = DivW'(prod_q);
      divisor  = DvsW'({den, 8'd0});
    end else begin
      dividend = DivW'({sum_q[cmd_i.chan], 8'd0});
      divisor  = valid_q[cmd_i.chan];
    end
  end

  ffc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= 16'd1;
      clamped_q <= '0;
      ovalid_q  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c]   <= '0;
        valid_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) floor_q <= cfg_floor_i;
      if (cmd_i.commit) begin
        clamped_q <= clamped_d;
        for (int c = 0; c < 3; c++) begin
          sum_q[c]   <= sum_d[c];
          valid_q[c] <= valid_d[c];
        end
      end
      if (cmd_i.commit) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      sat_q  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        img_q[c]  <= image_i[c];
        flat_q[c] <= flat_i[c];
      end
    end
    if (cmd_i.cap_norm) norm_q <= quotient[23:0];
    if (cmd_i.cap_prod) prod_q <= img_q[cmd_i.chan] * norm_q;
    if (cmd_i.cap_res) begin
      if (quotient[DivW-1:16] != '0) begin
        res_q[cmd_i.chan] <= 16'hFFFF;
        sat_q <= 1'b1;
      end else begin
        res_q[cmd_i.chan] <= quotient[15:0];
      end
    end
    if (cmd_i.commit) begin
      ovt_q <= 26'(valid_d[0]) + 26'(valid_d[1]) + 26'(valid_d[2]);
      oct_q <= clamped_d;
      for (int c = 0; c < 3; c++) begin
        osmp_q[c] <= (mode_q == ModeCorrect && all_valid) ? res_q[c] : 16'd0;
      end
      if (mode_q != ModeCorrect) ostat_q <= StatOk;
      else if (!all_valid) ostat_q <= StatNoValid;
      else ostat_q <= sat_q ? StatSat : StatOk;
    end
  end

  assign sts_o.need_div = (mode_q == ModeCorrect) && all_valid;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ovalid_q || out_ready_i;

  assign floor_o         = floor_q;
  assign out_valid_o     = ovalid_q;
  assign out_sample_o    = osmp_q;
  assign status_o        = ostat_q;
  assign valid_total_o   = ovt_q;
  assign clamped_total_o = oct_q;

  a_red_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] <= MaxValid && valid_q[1] <= MaxValid && valid_q[2] <= MaxValid)
    else $error("valid count beyond pixel limit");
  a_clamp_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clamped_q <= MaxClamped)
    else $error("clamped count beyond limit");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |=> ovalid_q && $stable(ostat_q))
    else $error("pending result word changed");

endmodule
